/* sv/slin_pkg.sv */
// ----------------------------------------------------------------------------
// slin_pkg
// Shared types and constants for the sensor ratio linearizer: payload
// structs, configuration register indexes, datapath operation codes.
// ----------------------------------------------------------------------------
package slin_pkg;

  // Converter scale: full scale count and K = full scale - 1
  localparam int unsigned ADC_FULL = 1024;
  localparam int unsigned ADC_K    = 1023;
  localparam int unsigned ADC_MV   = 5000;

  // Linear mode divisor d = 100*K, rounding form uses 2d
  localparam int unsigned LIN_D    = 100 * ADC_K;
  localparam int unsigned LIN_D2   = 200 * ADC_K;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_OFFSET = 2'd1;
  localparam logic [1:0] CFG_SPAN   = 2'd2;
  localparam logic [1:0] CFG_COUNT  = 2'd3;

  // Conversion modes
  localparam logic [1:0] MODE_NARROW = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_TABLE  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Input operations
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  // Datapath operation codes
  localparam logic [3:0] DP_NOP    = 4'd0;
  localparam logic [3:0] DP_NARROW = 4'd1;
  localparam logic [3:0] DP_LIN1   = 4'd2;
  localparam logic [3:0] DP_LIN2   = 4'd3;
  localparam logic [3:0] DP_CAP0   = 4'd4;
  localparam logic [3:0] DP_CAP1   = 4'd5;
  localparam logic [3:0] DP_TBL1   = 4'd6;
  localparam logic [3:0] DP_TBL2   = 4'd7;
  localparam logic [3:0] DP_TBL3   = 4'd8;
  localparam logic [3:0] DP_TBL4   = 4'd9;
  localparam logic [3:0] DP_DCHK   = 4'd10;
  localparam logic [3:0] DP_DSTEP  = 4'd11;
  localparam logic [3:0] DP_DEGEN  = 4'd12;
  localparam logic [3:0] DP_CLR    = 4'd13;

  typedef struct packed {
    logic        op;
    logic [6:0]  point_index;
    logic [12:0] point_voltage;
    logic [16:0] point_ratio;
    logic [9:0]  adc_sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] ratio_code;
    logic       degenerate_segment;
    logic       saturated;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic       wr;    // store breakpoint
    logic       load;  // latch sample, start conversion
    logic [3:0] op;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;    // sample voltage at or below read breakpoint
    logic degen;  // zero width segment
    logic fast;   // result settled without long division
  } sts_t;

endpackage

/* sv/slin_datapath.sv */
// ----------------------------------------------------------------------------
// slin_datapath
// Breakpoint memories, segment arithmetic and a restoring divider that
// produces an 8-bit quotient with saturation. Driven by slin_ctrl.
// ----------------------------------------------------------------------------
module slin_datapath #(
  parameter int unsigned MAX_POINTS = 128
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  slin_pkg::cmd_t                  cmd_i,
  input  logic [$clog2(MAX_POINTS)-1:0]   rd_addr_i,
  input  slin_pkg::in_item_t              item_i,
  input  logic [16:0]                     offset_i,
  input  logic [16:0]                     span_i,
  output slin_pkg::sts_t                  sts_o,
  output slin_pkg::out_item_t             res_o
);
  import slin_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);

  // Breakpoint storage, undefined until written
  logic [12:0] vmem [MAX_POINTS];
  logic [16:0] rmem [MAX_POINTS];
  logic [12:0] vrd_q;
  logic [16:0] rrd_q;

  // Operand and intermediate registers
  logic [9:0]         s_q;
  logic [22:0]        sv_q;
  logic [12:0]        v0_q, v1_q;
  logic [16:0]        a0_q, a1_q;
  logic signed [13:0] dv_q;
  logic signed [23:0] t_q;
  logic signed [17:0] da_q;
  logic [26:0]        a0k_q;
  logic signed [41:0] m1_q, m2_q;
  logic [22:0]        qv_q;
  logic signed [42:0] p_q;
  logic [29:0]        q100_q;
  logic [43:0]        num_q;
  logic [30:0]        den_q;
  logic               neg_q;
  logic [43:0]        rem_q;
  logic [38:0]        dsh_q;
  logic [7:0]         quo_q;
  logic [7:0]         code_q;
  logic               sat_q;
  logic               degen_q;

  // Combinational helpers
  logic [22:0]        vk;
  logic [22:0]        v0k;
  logic [12:0]        f13;
  logic [27:0]        lsum;
  logic [12:0]        absdv;
  logic signed [43:0] p44;
  logic signed [43:0] pp;
  logic signed [44:0] n2;
  logic               over;
  logic               ge;

  always_comb begin
    vk    = 23'(vrd_q) * 23'(ADC_K);
    v0k   = 23'(v0_q) * 23'(ADC_K);
    f13   = 13'(s_q) * 13'd5;
    lsum  = m1_q[27:0] + m2_q[27:0];
    absdv = dv_q[13] ? 13'(-dv_q) : 13'(dv_q);
    p44   = 44'(p_q);
    pp    = dv_q[13] ? -p44 : p44;
    n2    = $signed({pp, 1'b0}) + $signed(45'(q100_q));
    over  = num_q >= 44'({den_q, 8'd0});
    ge    = rem_q >= 44'(dsh_q);
  end

  // Memory write port and registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && (9'(item_i.point_index) < 9'(MAX_POINTS))) begin
      vmem[AW'(item_i.point_index)] <= item_i.point_voltage;
      rmem[AW'(item_i.point_index)] <= item_i.point_ratio;
    end
    vrd_q <= vmem[rd_addr_i];
    rrd_q <= rmem[rd_addr_i];
  end

  // Datapath registers, one operation per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q  <= item_i.adc_sample;
      sv_q <= 23'(item_i.adc_sample) * 23'(ADC_MV);
    end
    case (cmd_i.op)
      DP_NARROW: begin
        neg_q <= f13 > 13'(ADC_FULL);
        num_q <= 44'(13'(ADC_FULL) - f13);
        den_q <= 31'd5;
      end
      DP_LIN1: begin
        m1_q <= $signed(42'(27'(s_q) * 27'(span_i)));
        m2_q <= $signed(42'(27'(offset_i) * 27'(ADC_K)));
      end
      DP_LIN2: begin
        neg_q <= 1'b0;
        num_q <= 44'({lsum, 1'b0}) + 44'(LIN_D);
        den_q <= 31'(LIN_D2);
      end
      DP_CAP0: begin
        v0_q <= vrd_q;
        a0_q <= rrd_q;
      end
      DP_CAP1: begin
        v1_q <= vrd_q;
        a1_q <= rrd_q;
      end
      DP_TBL1: begin
        dv_q  <= $signed({1'b0, v1_q}) - $signed({1'b0, v0_q});
        t_q   <= $signed({1'b0, sv_q}) - $signed({1'b0, v0k});
        da_q  <= $signed({1'b0, a1_q}) - $signed({1'b0, a0_q});
        a0k_q <= 27'(a0_q) * 27'(ADC_K);
      end
      DP_TBL2: begin
        m1_q <= $signed({1'b0, a0k_q}) * dv_q;
        m2_q <= da_q * t_q;
        qv_q <= 23'(absdv) * 23'(ADC_K);
      end
      DP_TBL3: begin
        p_q    <= 43'(m1_q) + 43'(m2_q);
        q100_q <= 30'(qv_q) * 30'd100;
        den_q  <= 31'(qv_q) * 31'd200;
      end
      DP_TBL4: begin
        neg_q <= n2[44];
        num_q <= n2[43:0];
      end
      DP_DCHK: begin
        // negative result gives 0, a quotient of 256 or more saturates
        if (neg_q) begin
          code_q <= 8'd0;
          sat_q  <= 1'b0;
        end else if (over) begin
          code_q <= 8'hFF;
          sat_q  <= 1'b1;
        end else begin
          sat_q <= 1'b0;
        end
        rem_q <= num_q;
        dsh_q <= {den_q, 8'd0} >> 1;
        quo_q <= 8'd0;
      end
      DP_DSTEP: begin
        if (ge) begin
          rem_q <= rem_q - 44'(dsh_q);
        end
        quo_q  <= {quo_q[6:0], ge};
        code_q <= {quo_q[6:0], ge};
        dsh_q  <= dsh_q >> 1;
      end
      DP_DEGEN: begin
        code_q <= 8'hFF;
        sat_q  <= 1'b1;
      end
      DP_CLR: begin
        code_q <= 8'd0;
        sat_q  <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Degenerate flag is control-visible, cleared per conversion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degen_q <= 1'b0;
    end else if (cmd_i.load) begin
      degen_q <= 1'b0;
    end else if (cmd_i.op == DP_TBL1) begin
      degen_q <= (v1_q == v0_q);
    end
  end

  assign sts_o.hit   = sv_q <= vk;
  assign sts_o.degen = degen_q;
  assign sts_o.fast  = neg_q | over;

  assign res_o.ratio_code         = code_q;
  assign res_o.degenerate_segment = degen_q;
  assign res_o.saturated          = sat_q;

endmodule

/* sv/slin_ctrl.sv */
// ----------------------------------------------------------------------------
// slin_ctrl
// Sequencer for the linearizer: accepts transactions, walks the breakpoint
// table, steps the datapath through each mode and the divider.
// ----------------------------------------------------------------------------
module slin_ctrl #(
  parameter int unsigned MAX_POINTS = 128
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_op_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      mode_i,
  input  logic [7:0]                      count_i,
  input  logic                            out_free_i,
  input  slin_pkg::sts_t                  sts_i,
  output slin_pkg::cmd_t                  cmd_o,
  output logic [$clog2(MAX_POINTS)-1:0]   rd_addr_o,
  output logic                            res_load_o
);
  import slin_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_NB   = 4'd1;
  localparam logic [3:0] ST_LIN1 = 4'd2;
  localparam logic [3:0] ST_LIN2 = 4'd3;
  localparam logic [3:0] ST_SRCH = 4'd4;
  localparam logic [3:0] ST_RD0  = 4'd5;
  localparam logic [3:0] ST_RD1  = 4'd6;
  localparam logic [3:0] ST_RD2  = 4'd7;
  localparam logic [3:0] ST_TBL1 = 4'd8;
  localparam logic [3:0] ST_TBL2 = 4'd9;
  localparam logic [3:0] ST_TBL3 = 4'd10;
  localparam logic [3:0] ST_TBL4 = 4'd11;
  localparam logic [3:0] ST_DCHK = 4'd12;
  localparam logic [3:0] ST_DIV  = 4'd13;
  localparam logic [3:0] ST_CLR  = 4'd14;
  localparam logic [3:0] ST_DONE = 4'd15;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          chk_q, chk_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [2:0]    dcnt_q, dcnt_d;

  logic [8:0]    pc9;
  logic [8:0]    n9;
  logic [CW-1:0] n;
  logic [CW-1:0] seg;

  // Breakpoint count clamped to 2..MAX_POINTS; segment end at least 1
  always_comb begin
    pc9 = {1'b0, count_i};
    if (pc9 < 9'd2) begin
      n9 = 9'd2;
    end else if (pc9 > 9'(MAX_POINTS)) begin
      n9 = 9'(MAX_POINTS);
    end else begin
      n9 = pc9;
    end
    n   = CW'(n9);
    seg = (idx_q == '0) ? CW'(1) : idx_q;
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    chk_d      = chk_q;
    idx_d      = idx_q;
    dcnt_d     = dcnt_q;
    cmd_o      = '0;
    cmd_o.op   = DP_NOP;
    rd_addr_o  = AW'(cnt_q);
    res_load_o = 1'b0;
    in_stall_o = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == OP_WRITE) begin
            cmd_o.wr = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            cnt_d      = '0;
            chk_d      = 1'b0;
            case (mode_i)
              MODE_NARROW: state_d = ST_NB;
              MODE_LINEAR: state_d = ST_LIN1;
              MODE_TABLE:  state_d = ST_SRCH;
              default:     state_d = ST_CLR;
            endcase
          end
        end
      end
      ST_NB: begin
        cmd_o.op = DP_NARROW;
        state_d  = ST_DCHK;
      end
      ST_LIN1: begin
        cmd_o.op = DP_LIN1;
        state_d  = ST_LIN2;
      end
      ST_LIN2: begin
        cmd_o.op = DP_LIN2;
        state_d  = ST_DCHK;
      end
      // one slot issued per cycle, the previous slot's data compared
      ST_SRCH: begin
        if (chk_q && sts_i.hit) begin
          idx_d   = cnt_q - CW'(1);
          state_d = ST_RD0;
        end else if (cnt_q == n) begin
          idx_d   = n - CW'(1);
          state_d = ST_RD0;
        end else begin
          cnt_d = cnt_q + CW'(1);
          chk_d = 1'b1;
        end
      end
      ST_RD0: begin
        rd_addr_o = AW'(seg - CW'(1));
        state_d   = ST_RD1;
      end
      ST_RD1: begin
        rd_addr_o = AW'(seg);
        cmd_o.op  = DP_CAP0;
        state_d   = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.op = DP_CAP1;
        state_d  = ST_TBL1;
      end
      ST_TBL1: begin
        cmd_o.op = DP_TBL1;
        state_d  = ST_TBL2;
      end
      ST_TBL2: begin
        if (sts_i.degen) begin
          cmd_o.op = DP_DEGEN;
          state_d  = ST_DONE;
        end else begin
          cmd_o.op = DP_TBL2;
          state_d  = ST_TBL3;
        end
      end
      ST_TBL3: begin
        cmd_o.op = DP_TBL3;
        state_d  = ST_TBL4;
      end
      ST_TBL4: begin
        cmd_o.op = DP_TBL4;
        state_d  = ST_DCHK;
      end
      ST_DCHK: begin
        cmd_o.op = DP_DCHK;
        dcnt_d   = '0;
        state_d  = sts_i.fast ? ST_DONE : ST_DIV;
      end
      // eight quotient bits, most significant first
      ST_DIV: begin
        cmd_o.op = DP_DSTEP;
        dcnt_d   = dcnt_q + 3'd1;
        if (dcnt_q == 3'd7) begin
          state_d = ST_DONE;
        end
      end
      ST_CLR: begin
        cmd_o.op = DP_CLR;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          res_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      chk_q   <= 1'b0;
      idx_q   <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      chk_q   <= chk_d;
      idx_q   <= idx_d;
      dcnt_q  <= dcnt_d;
    end
  end

endmodule

/* sv/sensor_ratio_linearizer.sv */
// ----------------------------------------------------------------------------
// sensor_ratio_linearizer
// Converts a converter sample to a ratio code in tenths by narrow band,
// linear or breakpoint table interpolation; stores breakpoints.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  slin_pkg::in_item_t
//  out      output     out_valid/stall    slin_pkg::out_item_t
//  cfg      input      cfg_valid/ready    cfg_index, cfg_data (17 bits)
//
// One transaction at a time. Table mode adds the breakpoint walk, one slot
// per cycle, to the conversion. Reset clears control and configuration
// only; the breakpoint memory holds nothing until written. A finished
// result waits in the output register, and the next transaction is taken
// meanwhile.
// ----------------------------------------------------------------------------
module sensor_ratio_linearizer #(
  parameter int unsigned MAX_POINTS = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  slin_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output slin_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [16:0]          cfg_data_i
);
  import slin_pkg::*;

  logic [1:0]  mode_q;
  logic [16:0] offset_q;
  logic [16:0] span_q;
  logic [7:0]  count_q;

  cmd_t                          cmd;
  sts_t                          sts;
  out_item_t                     res;
  logic [$clog2(MAX_POINTS)-1:0] rd_addr;
  logic                          res_load;
  logic                          out_free;
  logic                          out_valid_q;
  out_item_t                     out_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_TABLE;
      offset_q <= 17'd10000;
      span_q   <= 17'd10000;
      count_q  <= 8'd4;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODE:   mode_q   <= cfg_data_i[1:0];
        CFG_OFFSET: offset_q <= cfg_data_i;
        CFG_SPAN:   span_q   <= cfg_data_i;
        CFG_COUNT:  count_q  <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  slin_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_q),
    .count_i    (count_q),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr),
    .res_load_o (res_load)
  );

  slin_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_addr_i (rd_addr),
    .item_i    (in_data_i),
    .offset_i  (offset_q),
    .span_i    (span_q),
    .sts_o     (sts),
    .res_o     (res)
  );

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sensor ratio linearizer. An in-bench predictor
// covers the narrow band, linear and table modes. Results are compared field
// by field in order. Handshakes idle and stall at random, and one long
// receiver hold-off fills the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import slin_pkg::*;

  localparam int unsigned SLOTS = 128;

  // Predicts ratio codes and holds them until the block produces them
  class ratio_scoreboard;
    logic [1:0]  mode;
    logic [16:0] offset, span;
    logic [7:0]  count;
    logic [12:0] bp_mv [SLOTS];
    logic [16:0] bp_ratio [SLOTS];
    out_item_t   awaited [$];
    int          mismatches, conversions, bp_writes;

    function void set_reg(logic [1:0] idx, logic [16:0] val);
      case (idx)
        CFG_MODE:   mode   = val[1:0];
        CFG_OFFSET: offset = val;
        CFG_SPAN:   span   = val;
        CFG_COUNT:  count  = val[7:0];
        default: ;
      endcase
    endfunction

    function void reset_regs();
      mode = MODE_TABLE; offset = 17'd10000; span = 17'd10000; count = 8'd4;
    endfunction

    // Table interpolation, exact, rounded half up in tenths
    function longint table_tenths(int s, output logic degen);
      longint k, v0, v1, a0, a1, dv, p, q, num;
      int n, i;
      k = ADC_K; degen = 1'b0;
      n = count;
      if (n < 2) n = 2;
      if (n > SLOTS) n = SLOTS;
      for (i = 0; i < n; i++)
        if (longint'(s) * ADC_MV <= longint'(bp_mv[i]) * k) break;
      if (i >= n) i = n - 1;
      if (i < 1) i = 1;
      v0 = bp_mv[i-1]; v1 = bp_mv[i];
      a0 = bp_ratio[i-1]; a1 = bp_ratio[i];
      dv = v1 - v0;
      if (dv == 0) begin
        degen = 1'b1;
        return 9990;
      end
      p = a0 * k * dv + (a1 - a0) * (longint'(s) * ADC_MV - v0 * k);
      q = k * dv;
      if (q < 0) begin
        p = -p; q = -q;
      end
      num = 2 * p + 100 * q;
      if (num < 0) return 0;
      return num / (200 * q);
    endfunction

    // Accepted input transaction: store a breakpoint or predict a result
    function void note(in_item_t it);
      longint    code, nn;
      logic      degen;
      out_item_t r;
      degen = 1'b0;
      if (it.op == OP_WRITE) begin
        bp_mv[it.point_index] = it.point_voltage;
        bp_ratio[it.point_index] = it.point_ratio;
        bp_writes++;
        return;
      end
      conversions++;
      case (mode)
        MODE_NARROW: code = (5 * it.adc_sample > ADC_FULL) ? 0
                            : (ADC_FULL - 5 * it.adc_sample) / 5;
        MODE_LINEAR: begin
          nn = longint'(offset) * ADC_K + longint'(it.adc_sample) * span;
          code = (2 * nn + LIN_D) / LIN_D2;
        end
        MODE_TABLE: code = table_tenths(it.adc_sample, degen);
        default: code = 0;
      endcase
      r.saturated = code > 255;
      r.ratio_code = (code > 255) ? 8'd255 : code[7:0];
      r.degenerate_segment = degen;
      awaited.push_back(r);
    endfunction

    function void check(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = awaited.pop_front();
      if (got.ratio_code !== want.ratio_code ||
          got.degenerate_segment !== want.degenerate_segment ||
          got.saturated !== want.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_item_t    in_data_i;
  out_item_t   out_data_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [16:0] cfg_data_i;

  ratio_scoreboard sb;
  int  send_idle_pct, stall_pct;
  bit  hold_req;
  int  hold_left;

  sensor_ratio_linearizer dut (.*);

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // Receiver stall, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_req) begin
        hold_left = 400; hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom % 100) < stall_pct;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) sb.check(out_data_o);

  task automatic send(in_item_t it);
    while (($urandom % 100) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i  <= in_item_t'(48'({$urandom, $urandom}));
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note(it);
  endtask

  task automatic write_bp(int idx, int mv, int ratio);
    in_item_t it;
    it = in_item_t'(48'({$urandom, $urandom}));
    it.op = OP_WRITE; it.point_index = 7'(idx);
    it.point_voltage = 13'(mv); it.point_ratio = 17'(ratio);
    send(it);
  endtask

  task automatic convert(int s);
    in_item_t it;
    it = in_item_t'(48'({$urandom, $urandom}));
    it.op = OP_CONVERT; it.adc_sample = 10'(s);
    send(it);
  endtask

  // Register update, only once the block has drained
  task automatic configure(int mode, int offset, int span, int count);
    logic [16:0] vals [4];
    vals = '{17'(mode), 17'(offset), 17'(span), 17'(count)};
    in_valid_i <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    for (int r = 0; r < 4; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 2'(r);
      cfg_data_i  <= vals[r];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(2'(r), vals[r]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Non-descending table over slots 0..127, with random steps
  task automatic fill_table();
    int mv;
    mv = $urandom_range(0, 40);
    for (int i = 0; i < SLOTS; i++) begin
      write_bp(i, mv, $urandom_range(0, 99999));
      mv += $urandom_range(0, 80);
      if (mv > 5100) mv = 5100;
    end
  endtask

  function automatic int pick_wide(int top);
    case ($urandom % 4)
      0: return 0;
      1: return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  initial begin
    int counts [6];
    sb = new();
    sb.reset_regs();
    counts = '{0, 1, 2, 128, 255, 4};
    send_idle_pct = 0; stall_pct = 0; hold_req = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0; in_data_i = '0;
    cfg_valid_i = 1'b0; cfg_index_i = CFG_MODE; cfg_data_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset table mode with four points, incl. a zero-width segment
    write_bp(0, 0, 99999);
    write_bp(1, 1000, 5000);
    write_bp(2, 1000, 20000);
    write_bp(3, 5100, 0);
    convert(0); convert(1023); convert(204); convert(700);
    // falling segment extrapolated below zero
    write_bp(2, 1200, 20000);
    write_bp(3, 1300, 0);
    convert(1023); convert(250);
    configure(MODE_NARROW, 0, 0, 2);
    convert(0); convert(204); convert(205); convert(1023);
    configure(MODE_LINEAR, 99999, 99999, 2);
    convert(0); convert(1023);
    configure(MODE_LINEAR, 0, 0, 4);
    convert(512);
    configure(MODE_UNUSED, 0, 0, 4);
    convert(1023);

    // Random: full non-descending table, then phases of mixed traffic
    configure(MODE_TABLE, 10000, 10000, 128);
    fill_table();
    for (int ph = 0; ph < 8; ph++) begin
      configure(ph == 0 ? MODE_TABLE : $urandom_range(0, 3), pick_wide(99999),
                pick_wide(99999), counts[$urandom % 6]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 88; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 88; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      if (ph == 4) hold_req = 1;
      for (int n = 0; n < 65; n++) begin
        if ($urandom % 5 == 0)
          write_bp($urandom % SLOTS, $urandom_range(0, 5100),
                   $urandom_range(0, 99999));
        else
          convert($urandom_range(0, 1023));
      end
    end
    in_valid_i <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("run covered %0d conversions and %0d breakpoint writes",
             sb.conversions, sb.bp_writes);
    $display("modes narrow, linear, table and unused, with varied point counts");
    if (sb.mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("testbench: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100ms;
    $display("timeout");
    $display("testbench: errors");
    $finish;
  end

endmodule
